// ===== rtl/l4co_pkg.sv =====
// Shared types and constants for the L4 checksum offset finder.
package l4co_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTpid0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTpid1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTpid2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgExt0 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgExt1 = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgExt2 = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgExt3 = 3'd6;

  localparam logic [15:0] EthLenMax = 16'd1500;
  localparam logic [15:0] MplsType = 16'h8847;
  localparam logic [15:0] Ip4Type = 16'h0800;
  localparam logic [15:0] Ip6Type = 16'h86DD;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [15:0] PosMax = 16'hFFFF;

  // Byte item passed from the front to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // Register set seen by the parser.
  typedef struct packed {
    logic [15:0] tpid0;
    logic [15:0] tpid1;
    logic [15:0] tpid2;
    logic [7:0]  ext0;
    logic [7:0]  ext1;
    logic [7:0]  ext2;
    logic [7:0]  ext3;
  } cfg_t;

endpackage

// ===== rtl/l4co_fifo.sv =====
// Two-entry queue between the front and the parser.
module l4co_fifo import l4co_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  byte_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output byte_item_t out_item_o
);

  byte_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

// ===== rtl/l4co_parser.sv =====
// Header parser: walks one byte per cycle unless a held result stalls it, and emits the offset on the last byte.
module l4co_parser import l4co_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  byte_item_t  in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_offset_o
);

  typedef enum logic [3:0] {
    PhEth, PhMpls, PhCw, PhIp4Ihl, PhIp4Proto,
    PhIp6Nh, PhExtNh, PhExtLen, PhDone, PhDead
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [16:0] nfp_q, nfp_d;
  logic [7:0]  proto_q, proto_d;
  logic [16:0] cand_q, cand_d;
  logic        ovld_q;
  logic [15:0] off_q;

  logic        accept;
  logic [16:0] idx;
  logic [7:0]  b;
  logic [31:0] sh;
  logic [15:0] v16;
  logic        in2, end2, in4, end4, at;
  logic        ext_hit_p, ext_hit_b;
  logic [17:0] csum;
  logic [17:0] ext_sum;
  logic        done_ok;
  logic [15:0] pos_after;

  assign in_ready_o  = !ovld_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;
  assign out_offset_o = off_q;

  assign idx = {1'b0, pos_q};
  assign b   = in_item_i.data;
  assign sh  = {shift_q[23:0], b};
  assign v16 = sh[15:0];
  assign in2  = (idx >= nfp_q) && (idx < nfp_q + 17'd2);
  assign end2 = (idx == nfp_q + 17'd1);
  assign in4  = (idx >= nfp_q) && (idx < nfp_q + 17'd4);
  assign end4 = (idx == nfp_q + 17'd3);
  assign at   = (idx == nfp_q);

  assign ext_hit_b = (b == cfg_i.ext0) || (b == cfg_i.ext1) ||
                     (b == cfg_i.ext2) || (b == cfg_i.ext3);
  assign ext_hit_p = (proto_q == cfg_i.ext0) || (proto_q == cfg_i.ext1) ||
                     (proto_q == cfg_i.ext2) || (proto_q == cfg_i.ext3);
  assign ext_sum = {1'b0, cand_q} + 18'd8 + {7'd0, b, 3'd0};

  // per-byte parse step
  always_comb begin
    logic [7:0]  p;
    logic [17:0] base;
    phase_d = phase_q;
    shift_d = shift_q;
    nfp_d   = nfp_q;
    proto_d = proto_q;
    cand_d  = cand_q;
    p    = proto_q;
    base = {1'b0, cand_q};
    csum = '0;
    if (pos_q != PosMax) begin
      case (phase_q)
        PhEth: if (in2) begin
          shift_d = sh;
          if (end2) begin
            shift_d = '0;
            if (nfp_q == 17'd12 && v16 <= EthLenMax) phase_d = PhDead;
            else if (v16 == cfg_i.tpid0 || v16 == cfg_i.tpid1 || v16 == cfg_i.tpid2)
              nfp_d = nfp_q + 17'd4;
            else begin
              nfp_d = nfp_q + 17'd2;
              if (v16 == MplsType) phase_d = PhMpls;
              else if (v16 == Ip4Type) phase_d = PhIp4Ihl;
              else if (v16 == Ip6Type) begin
                cand_d  = nfp_q + 17'd42;
                nfp_d   = nfp_q + 17'd8;
                phase_d = PhIp6Nh;
              end else phase_d = PhDead;
            end
          end
        end
        PhMpls: if (in4) begin
          shift_d = sh;
          if (end4) begin
            shift_d = '0;
            nfp_d = nfp_q + 17'd4;
            if (sh[8]) phase_d = PhCw;
          end
        end
        PhCw: if (in4) begin
          shift_d = sh;
          if (end4) begin
            shift_d = '0;
            if (sh == 32'd0) phase_d = PhDead;
            else if (sh[31:28] == 4'h4) begin
              cand_d  = nfp_q + {11'd0, sh[27:24], 2'b00};
              nfp_d   = nfp_q + 17'd9;
              phase_d = PhIp4Proto;
            end else if (sh[31:28] == 4'h6) begin
              cand_d  = nfp_q + 17'd40;
              nfp_d   = nfp_q + 17'd6;
              phase_d = PhIp6Nh;
            end else phase_d = PhDead;
          end
        end
        PhIp4Ihl: if (at) begin
          cand_d  = nfp_q + {11'd0, b[3:0], 2'b00};
          nfp_d   = nfp_q + 17'd9;
          phase_d = PhIp4Proto;
        end
        PhIp6Nh, PhIp4Proto: if (at) begin
          proto_d = b;
          if (phase_q == PhIp6Nh && ext_hit_b) begin
            nfp_d   = cand_q;
            phase_d = PhExtNh;
          end else begin
            p = b;
            phase_d = PhDead;
            if (p == ProtoTcp) begin
              csum = base + 18'd16;
              phase_d = PhDone;
            end else if (p == ProtoUdp) begin
              csum = base + 18'd6;
              phase_d = PhDone;
            end
            if (phase_d == PhDone) begin
              if (csum > 18'd65533) phase_d = PhDead;
              else cand_d = csum[16:0];
            end
          end
        end
        PhExtNh: if (at) begin
          proto_d = b;
          nfp_d   = nfp_q + 17'd1;
          phase_d = PhExtLen;
        end
        PhExtLen: if (at) begin
          // wide offsets can never be reached, so clamp to an unreachable value
          cand_d = ext_sum[17] ? 17'h1FFFF : ext_sum[16:0];
          if (ext_hit_p) begin
            nfp_d   = cand_d;
            phase_d = PhExtNh;
          end else begin
            base = ext_sum;
            phase_d = PhDead;
            if (p == ProtoTcp) begin
              csum = base + 18'd16;
              phase_d = PhDone;
            end else if (p == ProtoUdp) begin
              csum = base + 18'd6;
              phase_d = PhDone;
            end
            if (phase_d == PhDone) begin
              if (csum > 18'd65533) phase_d = PhDead;
              else cand_d = csum[16:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign pos_after = (pos_q != PosMax) ? pos_q + 16'd1 : pos_q;
  assign pos_d     = pos_after;
  assign done_ok   = (phase_d == PhDone) && (cand_d + 17'd2 <= {1'b0, pos_after});

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEth;
      pos_q   <= '0;
      shift_q <= '0;
      nfp_q   <= 17'd12;
      proto_q <= '0;
      cand_q  <= '0;
      ovld_q  <= 1'b0;
      off_q   <= '0;
    end else begin
      if (accept && in_item_i.last) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
      if (accept) begin
        if (in_item_i.last) begin
          phase_q <= PhEth;
          pos_q   <= '0;
          shift_q <= '0;
          nfp_q   <= 17'd12;
          proto_q <= '0;
          cand_q  <= '0;
          off_q   <= done_ok ? cand_d[15:0] : 16'd0;
        end else begin
          phase_q <= phase_d;
          pos_q   <= pos_d;
          shift_q <= shift_d;
          nfp_q   <= nfp_d;
          proto_q <= proto_d;
          cand_q  <= cand_d;
        end
      end
    end
  end

endmodule

// ===== rtl/l4_checksum_offset_finder_top.sv =====
// m_axis_tvalid_o rises once the last byte has passed the queue and then the result
// register; a stalled output holds it back further.
// One byte item per cycle unless the output stalls; the parse step is combinational.
// A two-entry queue decouples the input from the parser and result register.
// Reset (rst_ni low, asynchronous) empties the queue, restores register
// defaults and returns the parser to the EtherType stage.
module l4_checksum_offset_finder_top import l4co_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] data_byte
  input  logic                s_axis_tlast_i,  // frame_end
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o   // [15:0] checksum_offset
);

  cfg_t       cfg_q;
  byte_item_t in_item, q_item;
  logic       q_valid, q_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tpid0 <= 16'h8100;
      cfg_q.tpid1 <= 16'h88A8;
      cfg_q.tpid2 <= 16'h9100;
      cfg_q.ext0  <= 8'd0;
      cfg_q.ext1  <= 8'd43;
      cfg_q.ext2  <= 8'd44;
      cfg_q.ext3  <= 8'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTpid0: cfg_q.tpid0 <= cfg_data_i;
        CfgTpid1: cfg_q.tpid1 <= cfg_data_i;
        CfgTpid2: cfg_q.tpid2 <= cfg_data_i;
        CfgExt0:  cfg_q.ext0  <= cfg_data_i[7:0];
        CfgExt1:  cfg_q.ext1  <= cfg_data_i[7:0];
        CfgExt2:  cfg_q.ext2  <= cfg_data_i[7:0];
        CfgExt3:  cfg_q.ext3  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.data = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  l4co_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_item_o (q_item)
  );

  l4co_parser u_parser (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_offset_o(m_axis_tdata_o)
  );

endmodule
